/* src/tsf_pkg.sv */
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared widths, node codes, register map and point record for the
// tetrahedron shape function evaluator.
// ----------------------------------------------------------------------------
package tsf_pkg;

   // Field widths
   localparam int TAG_W        = 4;
   localparam int COORD_W      = 17;
   localparam int IDX_W        = 4;
   localparam int OUT_W        = 20;
   localparam int REQ_DATA_W   = 56;
   localparam int RSP_DATA_W   = 88;
   localparam int FRAC_BITS_DEF = 16;

   // Output saturation limits (signed 20 bit)
   localparam int OUT_MAX = 524287;
   localparam int OUT_MIN = -524288;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_ELEMENT_ORDER = 2'd0;
   localparam logic ORDER_LINEAR    = 1'b0;
   localparam logic ORDER_QUADRATIC = 1'b1;

   // Node numbers: corners, then edges
   localparam logic [IDX_W-1:0] N_CORNER_A = 4'd0;
   localparam logic [IDX_W-1:0] N_CORNER_1 = 4'd1;
   localparam logic [IDX_W-1:0] N_CORNER_2 = 4'd2;
   localparam logic [IDX_W-1:0] N_CORNER_3 = 4'd3;
   localparam logic [IDX_W-1:0] N_EDGE_1A  = 4'd4;
   localparam logic [IDX_W-1:0] N_EDGE_12  = 4'd5;
   localparam logic [IDX_W-1:0] N_EDGE_2A  = 4'd6;
   localparam logic [IDX_W-1:0] N_EDGE_3A  = 4'd7;
   localparam logic [IDX_W-1:0] N_EDGE_13  = 4'd8;
   localparam logic [IDX_W-1:0] N_EDGE_23  = 4'd9;

   // One accepted point, as handed from front to back
   typedef struct packed {
      logic               quad;
      logic [TAG_W-1:0]   tag;
      logic [COORD_W-1:0] coord_one;
      logic [COORD_W-1:0] coord_two;
      logic [COORD_W-1:0] coord_three;
   } point_type;

   localparam int POINT_W = $bits(point_type);

endpackage

/* src/tetra_shape_function_eval_core.sv */
// ----------------------------------------------------------------------------
// tetra_shape_function_eval_core
// Shape values and reference derivatives of a linear or quadratic
// tetrahedron at one barycentric point.
// ----------------------------------------------------------------------------
// Usage:
//   Send one point per word on the req_ channel (tag and L1, L2, L3 in
//   Q.FRAC_BITS). The block answers with one word per node on the rsp_
//   channel, in node order, rsp_tlast marking the final node: 10 words in
//   quadratic mode, 4 in linear mode. Select the mode through the
//   element_order register at csr_ address 0; write it only while idle.
//   An accepted point reaches its first node word through the queue,
//   operand, product and output stages behind the input register.
//   The node sequencer issues one node per cycle while the queue holds a
//   point and the output does not stall; meanwhile the input side keeps
//   accepting into a two-entry queue and a holding register.
//   When the receiver holds rsp_tready low, the output register holds its
//   word and the back pipeline freezes; the queue then fills and req_tready
//   drops. Reset empties the pipeline and queue and sets quadratic mode.
// ----------------------------------------------------------------------------
module tetra_shape_function_eval_core #(
   parameter int FRAC_BITS = tsf_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: point_tag[3:0], coord_one[20:4], coord_two[37:21],
   //        coord_three[54:38], zero fill[55]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tsf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tdata: point_tag_res[3:0], node_index[7:4], shape_value[27:8],
   //        deriv_r[47:28], deriv_s[67:48], deriv_t[87:68]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tsf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tsf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tsf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tsf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int AW = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
   localparam int QW = tsf_pkg::POINT_W + AW;

   logic                 order_ff, order_in;
   logic                 csr_wr;
   logic                 push, pop, q_full, q_empty;
   tsf_pkg::point_type   f_point, q_point;
   logic signed [AW-1:0] f_a, q_a;
   logic [QW-1:0]        q_rdata;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr == tsf_pkg::ADDR_ELEMENT_ORDER);
   assign order_in = csr_wr ? csr_pwdata[0] : order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= tsf_pkg::ORDER_QUADRATIC;
      end else begin
         order_ff <= order_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == tsf_pkg::ADDR_ELEMENT_ORDER) begin
         csr_prdata[0] = order_ff;
      end
   end

   tsf_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .order      (order_ff),
      .push       (push),
      .q_full     (q_full),
      .point_out  (f_point),
      .a_out      (f_a)
   );

   tsf_queue #(
      .DATA_W (QW),
      .DEPTH  (tsf_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata ({f_a, f_point}),
      .pop   (pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   assign q_point = q_rdata[tsf_pkg::POINT_W-1:0];
   assign q_a     = q_rdata[QW-1:tsf_pkg::POINT_W];

   tsf_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_point    (q_point),
      .q_a        (q_a),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/tsf_front.sv */
// ----------------------------------------------------------------------------
// tsf_front
// Input stage: accepts a point word, forms the fourth barycentric coordinate
// and holds the point until the queue takes it.
// ----------------------------------------------------------------------------
module tsf_front #(
   parameter int FRAC_BITS = tsf_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tsf_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            order,
   output logic                            push,
   input  logic                            q_full,
   output tsf_pkg::point_type              point_out,
   output logic signed [((FRAC_BITS > 19) ? FRAC_BITS : 19) + 1:0] a_out
);

   localparam int AW = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
   localparam int CW = tsf_pkg::COORD_W;
   localparam logic signed [AW-1:0] ONE_A =
      {{(AW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   logic                      valid_ff, valid_in;
   tsf_pkg::point_type        point_ff, point_in;
   logic signed [AW-1:0]      a_ff, a_in;
   logic                      take;

   // Accept while the holding register is free or draining this cycle
   assign req_tready = !valid_ff || !q_full;
   assign take       = req_tvalid && req_tready;
   assign push       = valid_ff && !q_full;

   // Unpack the word and form a = 1 - L1 - L2 - L3
   always_comb begin
      point_in.quad        = order;
      point_in.tag         = req_tdata[tsf_pkg::TAG_W-1:0];
      point_in.coord_one   = req_tdata[tsf_pkg::TAG_W +: CW];
      point_in.coord_two   = req_tdata[tsf_pkg::TAG_W + CW +: CW];
      point_in.coord_three = req_tdata[tsf_pkg::TAG_W + 2*CW +: CW];
      a_in = ONE_A
           - signed'({{(AW-CW){1'b0}}, point_in.coord_one})
           - signed'({{(AW-CW){1'b0}}, point_in.coord_two})
           - signed'({{(AW-CW){1'b0}}, point_in.coord_three});
      valid_in = take ? 1'b1 : (push ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (take) begin
         point_ff <= point_in;
         a_ff     <= a_in;
      end
   end

   assign point_out = point_ff;
   assign a_out     = a_ff;

endmodule

/* src/tsf_queue.sv */
// ----------------------------------------------------------------------------
// tsf_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module tsf_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = tsf_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wdata,
   input  logic              pop,
   output logic [DATA_W-1:0] rdata,
   output logic              full,
   output logic              empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNTW'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* src/tsf_back.sv */
// ----------------------------------------------------------------------------
// tsf_back
// Node sequencer and evaluation pipeline: walks the nodes of the queued
// point, selects multiplier operands and derivatives, multiplies, shifts,
// saturates and holds each node result in the output register.
// ----------------------------------------------------------------------------
module tsf_back #(
   parameter int FRAC_BITS = tsf_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  tsf_pkg::point_type              q_point,
   input  logic signed [((FRAC_BITS > 19) ? FRAC_BITS : 19) + 1:0] q_a,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tsf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int BASE = (FRAC_BITS > 19) ? FRAC_BITS : 19;
   localparam int W    = BASE + 5;         // derivative width
   localparam int MW   = BASE + 2;         // multiplier operand width
   localparam int PW   = 2 * MW;           // product width
   localparam int CW   = tsf_pkg::COORD_W;
   localparam int IW   = tsf_pkg::IDX_W;
   localparam int TW   = tsf_pkg::TAG_W;
   localparam int OW   = tsf_pkg::OUT_W;

   localparam logic signed [W-1:0] ONE_W =
      {{(W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [W-1:0]  D_MAX = W'(tsf_pkg::OUT_MAX);
   localparam logic signed [W-1:0]  D_MIN = W'(tsf_pkg::OUT_MIN);
   localparam logic signed [PW-1:0] P_MAX = PW'(tsf_pkg::OUT_MAX);
   localparam logic signed [PW-1:0] P_MIN = PW'(tsf_pkg::OUT_MIN);

   // Saturate a derivative to the output range
   function automatic logic [OW-1:0] sat_d(input logic signed [W-1:0] v);
      logic signed [W-1:0] c;
      c = v;
      if (v > D_MAX) c = D_MAX;
      if (v < D_MIN) c = D_MIN;
      return c[OW-1:0];
   endfunction

   // Sequencer
   logic [IW-1:0] node_ff, node_in;
   logic          adv, issue, last;

   // Operand and derivative select
   logic signed [W-1:0] l1, l2, l3, aw;
   logic signed [W-1:0] sel_a, sel_b, sel_r, sel_s, sel_t;

   // Stage 1: operands
   logic                 p1_valid_ff;
   logic signed [MW-1:0] p1_opa_ff, p1_opb_ff;
   logic signed [W-1:0]  p1_r_ff, p1_s_ff, p1_t_ff;
   logic [IW-1:0]        p1_node_ff;
   logic [TW-1:0]        p1_tag_ff;
   logic                 p1_last_ff;

   // Stage 2: product
   logic                 p2_valid_ff;
   logic signed [PW-1:0] p2_prod_ff;
   logic signed [W-1:0]  p2_r_ff, p2_s_ff, p2_t_ff;
   logic [IW-1:0]        p2_node_ff;
   logic [TW-1:0]        p2_tag_ff;
   logic                 p2_last_ff;

   // Output register
   logic                 out_valid_ff;
   logic [OW-1:0]        out_n_ff, out_r_ff, out_s_ff, out_t_ff;
   logic [IW-1:0]        out_node_ff;
   logic [TW-1:0]        out_tag_ff;
   logic                 out_last_ff;

   logic signed [PW-1:0] shifted;
   logic [OW-1:0]        shape_sat;

   // Whole pipeline moves when the output register is free or taken
   assign adv   = !out_valid_ff || rsp_tready;
   assign issue = adv && !q_empty;
   assign last  = q_point.quad ? (node_ff == tsf_pkg::N_EDGE_23)
                               : (node_ff == tsf_pkg::N_CORNER_3);
   assign pop   = issue && last;

   always_comb begin
      node_in = node_ff;
      if (issue) begin
         node_in = last ? '0 : node_ff + 1'b1;
      end
   end

   // Select per-node operands and derivatives
   always_comb begin
      l1 = signed'({{(W-CW){1'b0}}, q_point.coord_one});
      l2 = signed'({{(W-CW){1'b0}}, q_point.coord_two});
      l3 = signed'({{(W-CW){1'b0}}, q_point.coord_three});
      aw = W'(q_a);
      sel_a = '0;
      sel_b = ONE_W;
      sel_r = '0;
      sel_s = '0;
      sel_t = '0;
      if (q_point.quad == tsf_pkg::ORDER_LINEAR) begin
         // Value passes through a multiply by one
         case (node_ff)
            tsf_pkg::N_CORNER_A: begin
               sel_a = aw;
               sel_r = -ONE_W;
               sel_s = -ONE_W;
               sel_t = -ONE_W;
            end
            tsf_pkg::N_CORNER_1: begin
               sel_a = l1;
               sel_r = ONE_W;
            end
            tsf_pkg::N_CORNER_2: begin
               sel_a = l2;
               sel_s = ONE_W;
            end
            tsf_pkg::N_CORNER_3: begin
               sel_a = l3;
               sel_t = ONE_W;
            end
            default: begin
               sel_a = '0;
            end
         endcase
      end else begin
         case (node_ff)
            tsf_pkg::N_CORNER_A: begin
               sel_a = (aw <<< 1) - ONE_W;
               sel_b = aw;
               sel_r = ONE_W - (aw <<< 2);
               sel_s = ONE_W - (aw <<< 2);
               sel_t = ONE_W - (aw <<< 2);
            end
            tsf_pkg::N_CORNER_1: begin
               sel_a = l1;
               sel_b = (l1 <<< 1) - ONE_W;
               sel_r = (l1 <<< 2) - ONE_W;
            end
            tsf_pkg::N_CORNER_2: begin
               sel_a = l2;
               sel_b = (l2 <<< 1) - ONE_W;
               sel_s = (l2 <<< 2) - ONE_W;
            end
            tsf_pkg::N_CORNER_3: begin
               sel_a = l3;
               sel_b = (l3 <<< 1) - ONE_W;
               sel_t = (l3 <<< 2) - ONE_W;
            end
            tsf_pkg::N_EDGE_1A: begin
               sel_a = l1 <<< 2;
               sel_b = aw;
               sel_r = (aw - l1) <<< 2;
               sel_s = -(l1 <<< 2);
               sel_t = -(l1 <<< 2);
            end
            tsf_pkg::N_EDGE_12: begin
               sel_a = l1 <<< 2;
               sel_b = l2;
               sel_r = l2 <<< 2;
               sel_s = l1 <<< 2;
            end
            tsf_pkg::N_EDGE_2A: begin
               sel_a = l2 <<< 2;
               sel_b = aw;
               sel_r = -(l2 <<< 2);
               sel_s = (aw - l2) <<< 2;
               sel_t = -(l2 <<< 2);
            end
            tsf_pkg::N_EDGE_3A: begin
               sel_a = l3 <<< 2;
               sel_b = aw;
               sel_r = -(l3 <<< 2);
               sel_s = -(l3 <<< 2);
               sel_t = (aw - l3) <<< 2;
            end
            tsf_pkg::N_EDGE_13: begin
               sel_a = l1 <<< 2;
               sel_b = l3;
               sel_r = l3 <<< 2;
               sel_t = l1 <<< 2;
            end
            tsf_pkg::N_EDGE_23: begin
               sel_a = l2 <<< 2;
               sel_b = l3;
               sel_s = l3 <<< 2;
               sel_t = l2 <<< 2;
            end
            default: begin
               sel_a = '0;
            end
         endcase
      end
   end

   // Shift down the product (floor) and clamp
   always_comb begin
      shifted   = p2_prod_ff >>> FRAC_BITS;
      shape_sat = shifted[OW-1:0];
      if (shifted > P_MAX) shape_sat = P_MAX[OW-1:0];
      if (shifted < P_MIN) shape_sat = P_MIN[OW-1:0];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff      <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         node_ff <= node_in;
         if (adv) begin
            p1_valid_ff  <= issue;
            p2_valid_ff  <= p1_valid_ff;
            out_valid_ff <= p2_valid_ff;
         end
      end
   end

   // Advance payload through the stages
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_opa_ff  <= MW'(sel_a);
         p1_opb_ff  <= MW'(sel_b);
         p1_r_ff    <= sel_r;
         p1_s_ff    <= sel_s;
         p1_t_ff    <= sel_t;
         p1_node_ff <= node_ff;
         p1_tag_ff  <= q_point.tag;
         p1_last_ff <= last;

         p2_prod_ff <= PW'(p1_opa_ff) * PW'(p1_opb_ff);
         p2_r_ff    <= p1_r_ff;
         p2_s_ff    <= p1_s_ff;
         p2_t_ff    <= p1_t_ff;
         p2_node_ff <= p1_node_ff;
         p2_tag_ff  <= p1_tag_ff;
         p2_last_ff <= p1_last_ff;

         out_n_ff    <= shape_sat;
         out_r_ff    <= sat_d(p2_r_ff);
         out_s_ff    <= sat_d(p2_s_ff);
         out_t_ff    <= sat_d(p2_t_ff);
         out_node_ff <= p2_node_ff;
         out_tag_ff  <= p2_tag_ff;
         out_last_ff <= p2_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {out_t_ff, out_s_ff, out_r_ff, out_n_ff, out_node_ff, out_tag_ff};

endmodule
